// File: src/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg: shared types and constants of the sample splat accumulator.
// Request codes, channel widths and the control word between engine and top.
// ----------------------------------------------------------------------------
`default_nettype none
package ssa_pkg;
  localparam int unsigned ChanW   = 32;
  localparam int unsigned ValW    = 16;
  localparam int unsigned PosW    = 16;
  localparam int unsigned ScaleW  = 17;
  localparam int unsigned SizeW   = 9;
  localparam logic [31:0] Sat32   = 32'hFFFF_FFFF;

  localparam logic [1:0] REQ_SPLAT   = 2'd0;
  localparam logic [1:0] REQ_CENTER  = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_IGNORED = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  // Status the engine reports to the top level.
  typedef struct packed {
    logic busy;
    logic clearing;
  } ssa_status_t;
endpackage
`default_nettype wire

// File: src/ssa_ram.sv
// ----------------------------------------------------------------------------
// ssa_ram: generic single-port RAM with a registered read.
// One access per cycle; a write also returns the old entry on the read side.
// ----------------------------------------------------------------------------
`default_nettype none
module ssa_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: src/ssa_engine.sv
// ----------------------------------------------------------------------------
// ssa_engine: sequencer of read-modify-write passes on the accumulator RAM.
// Clears the RAM after reset, then walks up to nine cells per splat.
// ----------------------------------------------------------------------------
`default_nettype none
module ssa_engine
  import ssa_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = 256,
  parameter int unsigned IMG_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        req,
  input  wire logic [PosW-1:0]   px,
  input  wire logic [PosW-1:0]   py,
  input  wire logic [ValW-1:0]   vr,
  input  wire logic [ValW-1:0]   vg,
  input  wire logic [ValW-1:0]   vb,
  input  wire logic [SizeW-1:0]  width_in_use,
  input  wire logic [SizeW-1:0]  height_in_use,
  input  wire logic [ScaleW-1:0] sample_scale,
  input  wire logic              res_free,
  output ssa_status_t            status,
  output logic                   res_valid,
  output logic [3*ChanW-1:0]     res_data
);
  localparam int unsigned Depth = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned XW    = $clog2(IMG_WIDTH);
  localparam int unsigned YW    = $clog2(IMG_HEIGHT);
  localparam int unsigned S     = 1 << FRAC_BITS;
  localparam int unsigned OW    = FRAC_BITS + 2;   // overlap 0..S
  localparam int unsigned IW    = PosW - FRAC_BITS + 2; // signed cell index
  localparam int unsigned Sh    = 2 * FRAC_BITS;
  localparam int unsigned WW    = 2 * OW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADDR, ST_WAIT, ST_MOD, ST_WRITE, ST_OUT
  } state_t;

  state_t            state;
  logic [AW-1:0]     addr;
  logic              we;
  logic [3*ChanW-1:0] wdata, rdata;
  logic [3*ChanW-1:0] pix_q;
  logic [1:0]        req_q;
  logic [PosW-1:0]   px_q, py_q;
  logic [ValW-1:0]   v_q [3];
  logic [1:0]        di, dj;
  logic [OW-1:0]     ovx, ovy;
  logic [WW-1:0]     wgt;
  logic [ChanW-1:0]  add_q [3];
  logic [AW-1:0]     clr_addr;
  logic [12:0]       w_act, h_act;

  ssa_ram #(.WIDTH(3 * ChanW), .DEPTH(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Active size, limited to the image.
  always_comb begin
    w_act = (32'(width_in_use) > IMG_WIDTH) ? 13'(IMG_WIDTH) : 13'(width_in_use);
    h_act = (32'(height_in_use) > IMG_HEIGHT) ? 13'(IMG_HEIGHT) : 13'(height_in_use);
  end

  // Overlap along one axis of cell c with the box centred on p.
  function automatic logic [OW-1:0] overlap(input logic signed [IW:0] c,
                                            input logic [PosW-1:0] p);
    logic signed [PosW+FRAC_BITS+3:0] cs, lo, hi, mn, mx, ov;
    begin
      cs = (PosW+FRAC_BITS+4)'(c) <<< FRAC_BITS;
      lo = $signed({{(FRAC_BITS+4){1'b0}}, p}) - (PosW+FRAC_BITS+4)'(S / 2);
      hi = $signed({{(FRAC_BITS+4){1'b0}}, p}) + (PosW+FRAC_BITS+4)'(S / 2);
      mn = (cs < lo) ? cs : lo;
      mx = ((cs + (PosW+FRAC_BITS+4)'(S)) > hi) ? cs + (PosW+FRAC_BITS+4)'(S) : hi;
      ov = (PosW+FRAC_BITS+4)'(2 * S) - (mx - mn);
      overlap = (ov < 0) ? '0 : OW'(ov);
    end
  endfunction

  // Current neighbour cell and its bounds check.
  logic signed [IW:0] ci, cj;
  logic               in_img;
  always_comb begin
    ci = $signed({3'b000, px_q[PosW-1:FRAC_BITS]}) + $signed({{(IW-1){1'b0}}, di})
         - (IW+1)'(1);
    cj = $signed({3'b000, py_q[PosW-1:FRAC_BITS]}) + $signed({{(IW-1){1'b0}}, dj})
         - (IW+1)'(1);
    if (req_q != REQ_SPLAT) begin
      ci = $signed({3'b000, px_q[PosW-1:FRAC_BITS]});
      cj = $signed({3'b000, py_q[PosW-1:FRAC_BITS]});
    end
    in_img = (ci >= 0) && (cj >= 0) && (ci < $signed({1'b0, w_act}))
             && (cj < $signed({1'b0, h_act}));
  end

  // Saturating add of a gain.
  function automatic logic [ChanW-1:0] sat_add(input logic [ChanW-1:0] a,
                                               input logic [ChanW-1:0] b);
    logic [ChanW:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[ChanW] ? Sat32 : s[ChanW-1:0];
    end
  endfunction

  // Scaled readout with rounding and saturation.
  function automatic logic [ChanW-1:0] scale(input logic [ChanW-1:0] a,
                                             input logic [ScaleW-1:0] k);
    logic [ChanW+ScaleW:0] p;
    logic [ChanW+1:0] r;
    begin
      p = (ChanW+ScaleW+1)'(a) * (ChanW+ScaleW+1)'(k) + (ChanW+ScaleW+1)'(32768);
      r = p[ChanW+ScaleW:16];
      scale = (r > (ChanW+2)'(Sat32)) ? Sat32 : r[ChanW-1:0];
    end
  endfunction

  logic last_cell;
  assign last_cell = (req_q != REQ_SPLAT) || (di == 2'd2 && dj == 2'd2);

  assign status.busy     = (state != ST_IDLE);
  assign status.clearing = (state == ST_CLEAR);

  always_comb begin
    we    = 1'b0;
    addr  = clr_addr;
    wdata = '0;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else begin
      addr = AW'(32'(cj[YW-1:0]) * IMG_WIDTH + 32'(ci[XW-1:0]));
      if (state == ST_WRITE) begin
        we = 1'b1;
        wdata = {sat_add(rdata[3*ChanW-1:2*ChanW], add_q[2]),
                 sat_add(rdata[2*ChanW-1:ChanW], add_q[1]),
                 sat_add(rdata[ChanW-1:0], add_q[0])};
      end
    end
  end

  // Sequencer: one added cell takes ADDR, WAIT, MOD, WRITE; a read takes ADDR, WAIT, OUT.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      // Output register: loaded from the staged pixel when free, released when taken.
      if (state == ST_OUT && (!res_valid || res_free)) begin
        res_valid <= 1'b1;
        res_data  <= pix_q;
      end else if (res_valid && res_free) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(Depth - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            req_q <= req; px_q <= px; py_q <= py;
            v_q[0] <= vr; v_q[1] <= vg; v_q[2] <= vb;
            di <= 2'd0; dj <= 2'd0;
            state <= (req == REQ_IGNORED) ? ST_IDLE : ST_ADDR;
          end
        end
        ST_ADDR: begin
          ovx <= overlap(ci, px_q);
          ovy <= overlap(cj, py_q);
          if (!in_img && req_q == REQ_READ) begin
            pix_q <= '0;
            state <= ST_OUT;
          end else if (!in_img) begin
            if (last_cell) state <= ST_IDLE;
            else begin
              di <= (di == 2'd2) ? 2'd0 : di + 2'd1;
              if (di == 2'd2) dj <= dj + 2'd1;
            end
          end else state <= ST_WAIT;
        end
        ST_WAIT: begin
          wgt <= ovx * ovy;
          state <= (req_q == REQ_READ) ? ST_OUT : ST_MOD;
          if (req_q == REQ_READ) begin
            pix_q <= {scale(rdata[3*ChanW-1:2*ChanW], sample_scale),
                      scale(rdata[2*ChanW-1:ChanW], sample_scale),
                      scale(rdata[ChanW-1:0], sample_scale)};
          end
        end
        ST_MOD: begin
          for (int k = 0; k < 3; k++) begin
            logic [ValW+WW-1:0] g;
            g = (ValW+WW)'(v_q[k]) * (ValW+WW)'(wgt) + (ValW+WW)'(1 << (Sh - 1));
            add_q[k] <= (req_q == REQ_SPLAT) ? ChanW'(g >> Sh) : ChanW'(v_q[k]);
          end
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (last_cell) state <= ST_IDLE;
          else begin
            di <= (di == 2'd2) ? 2'd0 : di + 2'd1;
            if (di == 2'd2) dj <= dj + 2'd1;
            state <= ST_ADDR;
          end
        end
        ST_OUT: begin
          if (!res_valid || res_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/sample_splat_accumulator.sv
// ----------------------------------------------------------------------------
// sample_splat_accumulator: box-filter splat accumulation buffer.
//
//   channel   dir  fields
//   s_axis    in   tuser: req_type; tdata: pos_x, pos_y, sample_red/green/blue
//   m_axis    out  tdata: pixel_red, pixel_green, pixel_blue
//   cfg       in   width_in_use, height_in_use, sample_scale
//
// A splat walks up to nine cells on the single RAM port, each through
// ADDR, WAIT, MOD and WRITE; a skipped cell passes ADDR only. A center
// add is one such cell; a read goes ADDR, WAIT, OUT (ADDR, OUT outside).
// After reset all IMG_WIDTH*IMG_HEIGHT entries of the RAM are cleared
// with s_axis_tready low. A held result blocks only the next read.
// ----------------------------------------------------------------------------
`default_nettype none
module sample_splat_accumulator
  import ssa_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = 256,
  parameter int unsigned IMG_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // req_type[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  // pos_x[15:0], pos_y[31:16], red[47:32], green[63:48], blue[79:64]
  input  wire logic [79:0]   s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // pixel_red[31:0], pixel_green[63:32], pixel_blue[95:64]
  output logic [95:0]        m_axis_tdata,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [16:0]   cfg_data
);
  logic [SizeW-1:0]  width_in_use, height_in_use;
  logic [ScaleW-1:0] sample_scale;
  ssa_status_t       status;
  logic              start;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= SizeW'(256);
      height_in_use <= SizeW'(256);
      sample_scale  <= ScaleW'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_in_use  <= cfg_data[SizeW-1:0];
        REG_HEIGHT: height_in_use <= cfg_data[SizeW-1:0];
        REG_SCALE:  sample_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A new beat is taken whenever the engine is idle.
  assign s_axis_tready = !status.busy;
  assign start = s_axis_tvalid && s_axis_tready;

  ssa_engine #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT), .FRAC_BITS(FRAC_BITS))
  u_engine (
    .clk(clk), .rst(rst), .start(start),
    .req(s_axis_tuser), .px(s_axis_tdata[15:0]), .py(s_axis_tdata[31:16]),
    .vr(s_axis_tdata[47:32]), .vg(s_axis_tdata[63:48]), .vb(s_axis_tdata[79:64]),
    .width_in_use(width_in_use), .height_in_use(height_in_use),
    .sample_scale(sample_scale), .res_free(m_axis_tready), .status(status),
    .res_valid(m_axis_tvalid), .res_data(m_axis_tdata)
  );

  // No input is taken while the RAM is being cleared.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !s_axis_tready) else $error("input taken during clear");
  // A started item makes the engine busy or is an ignored code.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && s_axis_tuser != REQ_IGNORED |=> status.busy) else $error("item dropped");
  // No result appears while clearing.
  a_nores: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !m_axis_tvalid) else $error("result during clear");
endmodule
`default_nettype wire

// File: verif/sample_splat_accumulator_tb.sv
// ----------------------------------------------------------------------------
// sample_splat_accumulator_tb: self-checking bench for the splat accumulator.
// Beats are driven at the falling edge. An in-bench image model predicts each
// read beat, and a checker compares every output beat with the oldest pixel
// still pending. Several size and scale settings are covered, and both stream
// sides see random stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module sample_splat_accumulator_tb
  import ssa_pkg::*;
;

  localparam int ImgW = 256;
  localparam int ImgH = 256;
  localparam int Frac = 8;
  localparam int Unit = 1 << Frac;
  localparam int StallPct = 22;
  localparam int DrainCycles = 45;
  localparam int WatchLimit = 200000;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } splat_beat_t;

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  // Image model and its register copies.
  logic [31:0] img_red   [ImgW*ImgH];
  logic [31:0] img_green [ImgW*ImgH];
  logic [31:0] img_blue  [ImgW*ImgH];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [16:0] scale_reg;

  pixel_t pending_pixels[$];
  int     fail_count;
  bit     no_stall;
  int     quiet_cycles;

  sample_splat_accumulator DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int active_w();
    return (width_reg > ImgW) ? ImgW : int'(width_reg);
  endfunction

  function automatic int active_h();
    return (height_reg > ImgH) ? ImgH : int'(height_reg);
  endfunction

  // Overlap of one cell with the unit box around the sample, in 1/Unit steps.
  function automatic longint box_overlap(longint c, longint p);
    longint lo, hi, mn, mx, ov;
    lo = p - Unit / 2;
    hi = p + Unit / 2;
    mn = (c * Unit < lo) ? c * Unit : lo;
    mx = (c * Unit + Unit > hi) ? c * Unit + Unit : hi;
    ov = 2 * Unit - (mx - mn);
    return (ov < 0) ? 0 : ov;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] acc, longint unsigned add);
    longint unsigned s;
    s = longint'(acc) + add;
    return (s > 64'hFFFF_FFFF) ? Sat32 : s[31:0];
  endfunction

  function automatic logic [31:0] scaled(logic [31:0] acc);
    longint unsigned r;
    r = (longint'(acc) * longint'(scale_reg) + 32768) >> 16;
    return (r > 64'hFFFF_FFFF) ? Sat32 : r[31:0];
  endfunction

  // Apply one accepted beat to the image model and queue any read result.
  task automatic update_image(splat_beat_t b);
    int cx, cy, w, h, idx;
    longint oy;
    longint unsigned wgt;
    pixel_t p;
    cx = b.px >> Frac;
    cy = b.py >> Frac;
    w = active_w();
    h = active_h();
    case (b.req)
      REQ_SPLAT: begin
        for (int j = cy - 1; j <= cy + 1; j++) begin
          if (j < 0 || j >= h) continue;
          oy = box_overlap(j, b.py);
          for (int i = cx - 1; i <= cx + 1; i++) begin
            if (i < 0 || i >= w) continue;
            wgt = box_overlap(i, b.px) * oy;
            idx = j * ImgW + i;
            img_red[idx]   = sat_sum(img_red[idx],   (b.red   * wgt + 32768) >> 16);
            img_green[idx] = sat_sum(img_green[idx], (b.green * wgt + 32768) >> 16);
            img_blue[idx]  = sat_sum(img_blue[idx],  (b.blue  * wgt + 32768) >> 16);
          end
        end
      end
      REQ_CENTER: begin
        if (cx < w && cy < h) begin
          idx = cy * ImgW + cx;
          img_red[idx]   = sat_sum(img_red[idx],   b.red);
          img_green[idx] = sat_sum(img_green[idx], b.green);
          img_blue[idx]  = sat_sum(img_blue[idx],  b.blue);
        end
      end
      REQ_READ: begin
        p = '0;
        if (cx < w && cy < h) begin
          idx = cy * ImgW + cx;
          p.red   = scaled(img_red[idx]);
          p.green = scaled(img_green[idx]);
          p.blue  = scaled(img_blue[idx]);
        end
        pending_pixels.push_back(p);
      end
      default: ;
    endcase
  endtask

  function automatic splat_beat_t mk(logic [1:0] r, logic [15:0] x, logic [15:0] y,
                                     logic [15:0] vr, logic [15:0] vg, logic [15:0] vb);
    splat_beat_t b;
    b.req = r; b.px = x; b.py = y; b.red = vr; b.green = vg; b.blue = vb;
    return b;
  endfunction

  // Send one beat; called and returns at a falling edge.
  task automatic send_beat(splat_beat_t b);
    if (!no_stall) begin
      while ($urandom_range(0, 99) < StallPct) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.req;
    s_axis_tdata  <= {b.blue, b.green, b.red, b.py, b.px};
    do @(posedge clk); while (!s_axis_tready);
    update_image(b);
    @(negedge clk);
  endtask

  // Stop sending and let every pending read and trailing splat finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [16:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_WIDTH:  width_reg  = value[8:0];
      REG_HEIGHT: height_reg = value[8:0];
      REG_SCALE:  scale_reg  = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_image(int w, int h, int scale);
    drain();
    write_reg(REG_WIDTH, 17'(w));
    write_reg(REG_HEIGHT, 17'(h));
    write_reg(REG_SCALE, 17'(scale));
  endtask

  // Corners, exact centres, edge neighbours, ignored codes and outside reads.
  task automatic test_directed();
    send_beat(mk(REQ_READ, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0));
    send_beat(mk(REQ_CENTER, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h8001));
    send_beat(mk(REQ_CENTER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(REQ_SPLAT, 16'h0080, 16'h0080, 16'hFFFF, 16'h1234, 16'h0001));
    send_beat(mk(REQ_SPLAT, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(REQ_SPLAT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555));
    send_beat(mk(REQ_SPLAT, 16'h0140, 16'h01C0, 16'h7FFF, 16'h0100, 16'hFF00));
    send_beat(mk(REQ_IGNORED, 16'h0080, 16'h0080, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(REQ_READ, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0));
    send_beat(mk(REQ_READ, 16'h0100, 16'h0000, 16'h0, 16'h0, 16'h0));
    send_beat(mk(REQ_READ, 16'h0000, 16'h0100, 16'h0, 16'h0, 16'h0));
    send_beat(mk(REQ_READ, 16'h0101, 16'h01FF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(REQ_READ, 16'hFF00, 16'hFF00, 16'h0, 16'h0, 16'h0));
    send_beat(mk(REQ_READ, 16'hFE00, 16'hFF00, 16'h0, 16'h0, 16'h0));
    // Small image: neighbours and adds past the active edge are dropped.
    set_image(2, 2, 131071);
    send_beat(mk(REQ_SPLAT, 16'h0180, 16'h0180, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(REQ_CENTER, 16'h0200, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(REQ_READ, 16'h0100, 16'h0100, 16'h0, 16'h0, 16'h0));
    send_beat(mk(REQ_READ, 16'h0200, 16'h0100, 16'h0, 16'h0, 16'h0));
    send_beat(mk(REQ_READ, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0));
    // Zero size: every pixel is outside.
    set_image(0, 0, 0);
    send_beat(mk(REQ_CENTER, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(REQ_SPLAT, 16'h0080, 16'h0080, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(REQ_READ, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0));
  endtask

  // Random beats clustered on and just around the active area so reads see accumulated data.
  task automatic test_random(int count, int w, int h, int scale);
    splat_beat_t b;
    int pick, lim_x, lim_y;
    set_image(w, h, scale);
    lim_x = (active_w() + 1 > 255) ? 255 : active_w() + 1;
    lim_y = (active_h() + 1 > 255) ? 255 : active_h() + 1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      b.req = (pick < 45) ? REQ_SPLAT : (pick < 65) ? REQ_CENTER :
              (pick < 95) ? REQ_READ : REQ_IGNORED;
      if ($urandom_range(0, 9) == 0) begin
        b.px = 16'($urandom);
        b.py = 16'($urandom);
      end else begin
        b.px = {8'($urandom_range(0, lim_x)), 8'($urandom)};
        b.py = {8'($urandom_range(0, lim_y)), 8'($urandom)};
      end
      b.red   = 16'($urandom);
      b.green = 16'($urandom);
      b.blue  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      send_beat(b);
    end
  endtask

  // Sender holds off until every pending read has returned.
  task automatic test_hold_off();
    send_beat(mk(REQ_CENTER, 16'h0300, 16'h0200, 16'h1111, 16'h2222, 16'h3333));
    send_beat(mk(REQ_READ, 16'h0300, 16'h0200, 16'h0, 16'h0, 16'h0));
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    send_beat(mk(REQ_READ, 16'h0300, 16'h0200, 16'h0, 16'h0, 16'h0));
  endtask

  // Output side stalls at random except during the no-stall stretch.
  always @(negedge clk) begin
    m_axis_tready <= no_stall ? 1'b1 : ($urandom_range(0, 99) >= StallPct);
  end

  // Compare each output beat with the oldest pending pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected output beat %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[31:0] !== want.red) begin
          $error("pixel_red: expected %0d actual %0d", want.red, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[63:32] !== want.green) begin
          $error("pixel_green: expected %0d actual %0d", want.green, m_axis_tdata[63:32]);
          fail_count++;
        end
        if (m_axis_tdata[95:64] !== want.blue) begin
          $error("pixel_blue: expected %0d actual %0d", want.blue, m_axis_tdata[95:64]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = REQ_SPLAT;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    fail_count = 0;
    no_stall = 1'b0;
    quiet_cycles = 0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    scale_reg = 17'd65536;
    for (int i = 0; i < ImgW * ImgH; i++) begin
      img_red[i] = '0;
      img_green[i] = '0;
      img_blue[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(250, 256, 256, 65536);
    no_stall = 1'b1;
    test_random(250, 6, 4, 32768);
    no_stall = 1'b0;
    test_hold_off();
    test_random(250, 1, 1, 0);
    test_random(250, 511, 300, 131071);
    test_random(200, 17, 3, 1);
    test_random(250, 9, 200, $urandom_range(0, 131071));

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
